FILE: src/ffa_pkg.sv
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int ID_BITS_DEF    = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic shift_up;    // cells above pos take the left neighbor
    logic shift_down;  // cells at or above pos take the right neighbor
    logic load;        // cell at pos takes the new entry
  } cell_cmd_t;
endpackage

FILE: src/ffa_if.sv
`timescale 1ns / 1ps
interface ffa_in_if #(parameter int ID_BITS = 32, parameter int COUNT_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [COUNT_BITS-1:0] count;
  logic [ID_BITS-1:0]    start_req;
  modport source (output valid, opcode, count, start_req, input ready);
  modport sink (input valid, opcode, count, start_req, output ready);
endinterface

interface ffa_out_if #(parameter int ID_BITS = 32);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ID_BITS-1:0] base_id;
  logic [ID_BITS-1:0] last_id;
  modport source (output valid, status, base_id, last_id, input ready);
  modport sink (input valid, status, base_id, last_id, output ready);
endinterface

FILE: src/ffa_cell.sv
`timescale 1ns / 1ps
// One table slot. Computes its own gap flag from its left neighbor's end and its match flag from the requested start.
module ffa_cell #(
  parameter int ID_BITS    = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ffa_pkg::cell_cmd_t    cmd,
  input  logic                  at_pos,     // this slot is the insert/remove point
  input  logic                  above_pos,  // this slot is above the point
  input  logic [ID_BITS-1:0]    new_start,
  input  logic [COUNT_BITS-1:0] new_len,
  input  logic                  lft_valid,
  input  logic [ID_BITS-1:0]    lft_start,
  input  logic [COUNT_BITS-1:0] lft_len,
  input  logic                  rgt_valid,
  input  logic [ID_BITS-1:0]    rgt_start,
  input  logic [COUNT_BITS-1:0] rgt_len,
  input  logic [ID_BITS-1:0]    cand_in,    // first free id after left neighbor
  input  logic [COUNT_BITS-1:0] req_cnt,
  input  logic [ID_BITS-1:0]    req_start,
  output logic                  valid_o,
  output logic [ID_BITS-1:0]    start_o,
  output logic [COUNT_BITS-1:0] len_o,
  output logic                  fit_o,
  output logic                  match_o,
  output logic [ID_BITS-1:0]    cand_o,
  output logic                  top_o
);
  import ffa_pkg::*;

  logic                  valid_r;
  logic [ID_BITS-1:0]    start_r;
  logic [COUNT_BITS-1:0] len_r;
  logic [ID_BITS:0]      end_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.load && at_pos) begin
      valid_r <= 1'b1;
    end else if (cmd.shift_up && above_pos) begin
      valid_r <= lft_valid;
    end else if (cmd.shift_down && (at_pos || above_pos)) begin
      valid_r <= rgt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      len_r   <= '0;
    end else if (cmd.load && at_pos) begin
      start_r <= new_start;
      len_r   <= new_len;
    end else if (cmd.shift_up && above_pos) begin
      start_r <= lft_start;
      len_r   <= lft_len;
    end else if (cmd.shift_down && (at_pos || above_pos)) begin
      start_r <= rgt_start;
      len_r   <= rgt_len;
    end
  end

  assign end_x   = {1'b0, start_r} + {{(ID_BITS+1-COUNT_BITS){1'b0}}, len_r};
  // gap from cand to start; cand is 0 after a top block so start >= cand holds
  assign fit_o   = valid_r && (start_r >= cand_in) &&
                   ((start_r - cand_in) >= {{(ID_BITS-COUNT_BITS){1'b0}}, req_cnt});
  assign match_o = valid_r && (start_r == req_start);
  assign top_o   = end_x[ID_BITS];
  assign cand_o  = end_x[ID_BITS-1:0];
  assign valid_o = valid_r;
  assign start_o = start_r;
  assign len_o   = len_r;
endmodule

FILE: src/first_fit_id_block_allocator.sv
`timescale 1ns / 1ps
// An accepted item is evaluated in S_EVAL, then its result is presented in S_OUT.
// One item at a time, plus any output stall: accept, compare the whole row of cells
// at once, then hold the result while the row shifts; a new item is taken only in S_IDLE.
// Reset (rst_n, synchronous): table empty, lowest_id back to 1, no result pending.
module first_fit_id_block_allocator
  import ffa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ID_BITS-1:0] cfg_wdata,
  ffa_in_if.sink             in_ch,
  ffa_out_if.source          out_ch
);
  localparam int PW = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_OUT} state_t;

  state_t                state_r;
  logic [ID_BITS-1:0]    lowest_r;
  logic [PW-1:0]         total_r;
  logic                  op_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [ID_BITS-1:0]    sreq_r;
  logic [1:0]            status_r;
  logic [ID_BITS-1:0]    first_r, last_r;
  logic [PW-1:0]         pos_r;
  cell_cmd_t             cmd_r;
  logic [ID_BITS-1:0]    newst_r;

  logic                  c_valid [MAX_BLOCKS];
  logic [ID_BITS-1:0]    c_start [MAX_BLOCKS];
  logic [COUNT_BITS-1:0] c_len   [MAX_BLOCKS];
  logic                  c_fit   [MAX_BLOCKS];
  logic                  c_match [MAX_BLOCKS];
  logic [ID_BITS-1:0]    c_cand  [MAX_BLOCKS];
  logic                  c_top   [MAX_BLOCKS];

  genvar g;
  generate
    for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      logic                  lv, rv;
      logic [ID_BITS-1:0]    ls, rs, ci;
      logic [COUNT_BITS-1:0] ll, rl;
      if (g == 0) begin : g_first
        assign lv = 1'b0; assign ls = '0; assign ll = '0;
        assign ci = lowest_r;
      end else begin : g_mid
        assign lv = c_valid[g-1]; assign ls = c_start[g-1]; assign ll = c_len[g-1];
        assign ci = c_top[g-1] ? '0 : c_cand[g-1];
      end
      if (g == MAX_BLOCKS-1) begin : g_last
        assign rv = 1'b0; assign rs = '0; assign rl = '0;
      end else begin : g_inner
        assign rv = c_valid[g+1]; assign rs = c_start[g+1]; assign rl = c_len[g+1];
      end
      ffa_cell #(.ID_BITS(ID_BITS), .COUNT_BITS(COUNT_BITS)) u_cell (
        .clk, .rst_n, .cmd(cmd_r),
        .at_pos(pos_r == PW'(g)), .above_pos(pos_r < PW'(g)),
        .new_start(newst_r), .new_len(cnt_r),
        .lft_valid(lv), .lft_start(ls), .lft_len(ll),
        .rgt_valid(rv), .rgt_start(rs), .rgt_len(rl),
        .cand_in(ci), .req_cnt(cnt_r), .req_start(sreq_r),
        .valid_o(c_valid[g]), .start_o(c_start[g]), .len_o(c_len[g]),
        .fit_o(c_fit[g]), .match_o(c_match[g]), .cand_o(c_cand[g]), .top_o(c_top[g])
      );
    end
  endgenerate

  // priority scan for the first fitting gap and first matching start
  logic [PW-1:0]      fit_pos, hit_pos;
  logic               fit_any, hit_any;
  logic [ID_BITS-1:0] tail_cand;
  logic               tail_top;
  always_comb begin
    fit_pos = total_r; fit_any = 1'b0;
    hit_pos = '0;      hit_any = 1'b0;
    tail_cand = lowest_r; tail_top = 1'b0;
    for (int k = MAX_BLOCKS-1; k >= 0; k--) begin
      if (c_fit[k])   begin fit_pos = PW'(k); fit_any = 1'b1; end
      if (c_match[k]) begin hit_pos = PW'(k); hit_any = 1'b1; end
    end
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (c_valid[k]) begin
        tail_top  = c_top[k];
        tail_cand = c_top[k] ? '0 : c_cand[k];
      end
    end
  end

  function automatic logic [ID_BITS-1:0] c_cand_sel(input logic [PW-1:0] p);
    logic [ID_BITS-1:0] r;
    r = '0;
    for (int k = 1; k < MAX_BLOCKS; k++)
      if (p == PW'(k)) r = c_top[k-1] ? '0 : c_cand[k-1];
    return r;
  endfunction

  logic [ID_BITS-1:0]    eff_cand;
  logic [COUNT_BITS-1:0] cm1;
  logic [ID_BITS:0]      room;
  assign eff_cand = fit_any ? (fit_pos == '0 ? lowest_r : c_cand_sel(fit_pos)) : tail_cand;
  assign cm1  = cnt_r - 1'b1;
  assign room = {1'b0, ~eff_cand};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      lowest_r <= ID_BITS'(1);
      total_r  <= '0;
      cmd_r    <= '0;
    end else begin
      cmd_r <= '0;
      if (cfg_we && total_r == '0 && cfg_wdata != '0) lowest_r <= cfg_wdata;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= in_ch.opcode;
            cnt_r   <= (in_ch.count == '0) ? COUNT_BITS'(1) : in_ch.count;
            sreq_r  <= in_ch.start_req;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          first_r <= '0; last_r <= '0;
          if (op_r == OP_RELEASE) begin
            if (hit_any) begin
              status_r <= ST_DONE; pos_r <= hit_pos;
              cmd_r.shift_down <= 1'b1; total_r <= total_r - 1'b1;
            end else status_r <= ST_NOT_FOUND;
          end else if (total_r >= PW'(MAX_BLOCKS)) begin
            status_r <= ST_FULL;
          end else if ((!fit_any && tail_top) ||
                       ({{(ID_BITS+1-COUNT_BITS){1'b0}}, cm1} > room)) begin
            status_r <= ST_EXHAUSTED;
          end else begin
            status_r <= ST_DONE; pos_r <= fit_pos; newst_r <= eff_cand;
            first_r <= eff_cand;
            last_r  <= eff_cand + {{(ID_BITS-COUNT_BITS){1'b0}}, cm1};
            cmd_r.shift_up <= 1'b1; cmd_r.load <= 1'b1;
            total_r <= total_r + 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = (state_r == S_OUT);
  assign out_ch.status   = status_r;
  assign out_ch.base_id  = first_r;
  assign out_ch.last_id  = last_r;

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= PW'(MAX_BLOCKS)) else $error("entry count overflow");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_r.shift_up && cmd_r.shift_down)) else $error("conflicting cell commands");
  a_lowest: assert property (@(posedge clk) disable iff (!rst_n)
    lowest_r != '0) else $error("lowest id zero");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_DONE |-> out_ch.base_id == '0)
    else $error("error result carries an id");
endmodule

FILE: verif/ffa_checker.sv
`timescale 1ns / 1ps
module ffa_checker
  import ffa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ID_BITS-1:0] cfg_wdata,
  ffa_in_if                  in_ch,
  ffa_out_if                 out_ch,
  output int                 fail_count,
  output int                 pending,
  output int                 result_total
);
  typedef struct {
    status_t          status;
    logic [ID_BITS-1:0] base_id;
    logic [ID_BITS-1:0] last_id;
  } grant_t;

  localparam logic [ID_BITS:0] ID_TOP = {1'b0, {ID_BITS{1'b1}}};

  logic [ID_BITS-1:0]    blk_start [MAX_BLOCKS];
  logic [COUNT_BITS:0]   blk_len   [MAX_BLOCKS];
  int                    blk_total;
  logic [ID_BITS-1:0]    floor_id;
  grant_t                grant_q[$];

  function automatic grant_t reserve_blocks(logic [COUNT_BITS-1:0] cnt_in);
    grant_t           g;
    logic [ID_BITS:0] cand;
    logic [ID_BITS:0] cnt;
    logic [ID_BITS:0] last_of;
    int               pos;
    bit               at_top;
    g.status = ST_DONE; g.base_id = '0; g.last_id = '0;
    cnt = (cnt_in == 0) ? 1 : cnt_in;
    cand = floor_id;
    at_top = 0;
    if (blk_total >= MAX_BLOCKS) begin
      g.status = ST_FULL;
      return g;
    end
    pos = blk_total;
    for (int k = 0; k < blk_total; k++) begin
      if (blk_start[k] >= cand && blk_start[k] - cand >= cnt) begin
        pos = k;
        break;
      end
      last_of = blk_start[k] + blk_len[k] - 1;
      if (last_of >= ID_TOP) begin
        at_top = 1;
        cand = 0;
      end else begin
        at_top = 0;
        cand = last_of + 1;
      end
    end
    if ((pos == blk_total && at_top) || (cnt - 1 > ID_TOP - cand)) begin
      g.status = ST_EXHAUSTED;
      return g;
    end
    for (int k = blk_total; k > pos; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_len[k] = blk_len[k-1];
    end
    blk_start[pos] = cand[ID_BITS-1:0];
    blk_len[pos] = cnt[COUNT_BITS:0];
    blk_total++;
    g.base_id = cand[ID_BITS-1:0];
    g.last_id = ID_BITS'(cand + cnt - 1);
    return g;
  endfunction

  function automatic grant_t release_block(logic [ID_BITS-1:0] s);
    grant_t g;
    int     hit;
    g.status = ST_NOT_FOUND; g.base_id = '0; g.last_id = '0;
    hit = -1;
    for (int k = 0; k < blk_total; k++)
      if (blk_start[k] == s) begin
        hit = k;
        break;
      end
    if (hit < 0) return g;
    for (int k = hit; k + 1 < blk_total; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_len[k] = blk_len[k+1];
    end
    blk_total--;
    g.status = ST_DONE;
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (!rst_n) begin
      blk_total = 0;
      floor_id = 1;
      grant_q.delete();
      fail_count = 0;
      result_total = 0;
    end else begin
      if (cfg_we && cfg_wdata != 0 && blk_total == 0) floor_id = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        result_total++;
        got.status = status_t'(out_ch.status);
        got.base_id = out_ch.base_id;
        got.last_id = out_ch.last_id;
        if (grant_q.size() == 0) begin
          $error("result with nothing expected: status %0d", got.status);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.base_id != want.base_id) begin
            $error("base_id: expected %0h, got %0h", want.base_id, got.base_id);
            fail_count++;
          end
          if (got.last_id != want.last_id) begin
            $error("last_id: expected %0h, got %0h", want.last_id, got.last_id);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        grant_q.push_back(in_ch.opcode == OP_RESERVE ? reserve_blocks(in_ch.count)
                                                     : release_block(in_ch.start_req));
    end
    pending = grant_q.size();
  end

  // blocks the testbench may release; read by the stimulus
  function automatic logic [ID_BITS-1:0] held_start(int idx);
    return blk_total == 0 ? '1 : blk_start[idx % blk_total];
  endfunction

  function automatic int held_total();
    return blk_total;
  endfunction
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ffa_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          result_total;
  int          cycle_count;
  int          send_idle;
  int          recv_stall;
  bit          hold_off;
  int          reserve_total;
  int          release_total;

  ffa_in_if  #(.ID_BITS(32), .COUNT_BITS(16)) in_ch();
  ffa_out_if #(.ID_BITS(32)) out_ch();

  first_fit_id_block_allocator DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  ffa_checker CHK (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count),
    .pending(pending), .result_total(result_total)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  always @(posedge clk) begin
    cycle_count <= rst_n ? cycle_count + 1 : 0;
    if (cycle_count > 400000) begin
      $display("** first_fit_id_block_allocator: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // leaves valid high after the accept; the next call replaces it and drain() drops it
  task automatic send_item(logic op, logic [15:0] cnt, logic [31:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.count <= cnt;
    in_ch.start_req <= s;
    if (op == OP_RESERVE) reserve_total++;
    else release_total++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_floor(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic release_all();
    while (CHK.held_total() != 0) begin
      send_item(OP_RELEASE, '0, CHK.held_start(0));
      drain();
    end
  endtask

  task automatic random_item();
    int r;
    logic [15:0] cnt;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0: cnt = 16'($urandom);
      default: cnt = 16'($urandom_range(8));
    endcase
    if (r < 55) send_item(OP_RESERVE, cnt, $urandom);
    else if (r < 90) send_item(OP_RELEASE, cnt, CHK.held_start($urandom_range(15)));
    else send_item(OP_RELEASE, cnt, $urandom);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_RESERVE;
    in_ch.count = '0;
    in_ch.start_req = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_off = 1'b0;
    reserve_total = 0;
    release_total = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: default floor, extremes, fill and overflow
    send_item(OP_RESERVE, 16'd0, '0);
    send_item(OP_RESERVE, 16'hFFFF, 32'hFFFFFFFF);
    send_item(OP_RELEASE, '0, 32'd1);
    send_item(OP_RELEASE, '0, 32'd1);
    send_item(OP_RESERVE, 16'd3, '0);
    drain();
    write_floor(32'd500);        // ignored: table not empty
    release_all();
    write_floor(32'd0);          // ignored: zero
    write_floor(32'hFFFFFFF0);
    send_item(OP_RESERVE, 16'd16, '0);
    send_item(OP_RESERVE, 16'd1, '0);
    send_item(OP_RESERVE, 16'd1, '0);
    drain();
    release_all();
    write_floor(32'hFFFFFFFF);
    send_item(OP_RESERVE, 16'd1, '0);
    send_item(OP_RESERVE, 16'd1, '0);
    send_item(OP_RESERVE, 16'd2, '0);
    drain();
    release_all();
    write_floor(32'd1);
    for (int k = 0; k < 17; k++) send_item(OP_RESERVE, 16'd2, '0);
    send_item(OP_RELEASE, '0, 32'd5);
    send_item(OP_RESERVE, 16'd1, '0);
    drain();
    release_all();

    // random phases over idle/stall mixes and floors
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 31; recv_stall = 31; end
      endcase
      case (ph)
        3: write_floor(32'hFFFF0000);
        5: write_floor(32'h80000000);
        6: write_floor($urandom_range(1000, 1));
        default: write_floor(32'd1);
      endcase
      if (ph == 2) begin
        hold_off = 1'b1;
        fork
          begin repeat (60) @(negedge clk); hold_off = 1'b0; end
          for (int k = 0; k < 12; k++) random_item();
        join
      end
      for (int k = 0; k < 120; k++) random_item();
      drain();
      release_all();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();
    $display("ran %0d reserve and %0d release items, %0d results checked",
             reserve_total, release_total, result_total);
    $display("floors from 1 to the top of the id range, all idle and stall mixes");
    if (fail_count == 0) $display("** first_fit_id_block_allocator: PASSED **");
    else $display("** first_fit_id_block_allocator: FAILED **");
    $finish;
  end
endmodule
